>>> sv/rmj_pkg.sv
// Shared types and constants of the radar measurement Jacobian pipeline.
`timescale 1ns / 1ps
package rmj_pkg;

  localparam int DATA_W   = 32;
  localparam int FRAC_W   = 16;
  localparam int SQ_W     = 2 * DATA_W;
  localparam int ROOT_W   = DATA_W;
  localparam int QBITS    = DATA_W + 1;
  localparam int SQRT_LAT = ROOT_W;
  localparam int DIV_LAT  = QBITS + 2;
  localparam int PROD_W   = 3 * DATA_W;

  localparam logic [DATA_W-1:0] MIN_RANGE_SQ_RESET = 32'd7;
  localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

  localparam int DEF_NUM_W = DATA_W + FRAC_W;
  localparam int DEF_DEN_W = DATA_W;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] range_by_px;
    logic signed [DATA_W-1:0] range_by_py;
    logic signed [DATA_W-1:0] bearing_by_px;
    logic signed [DATA_W-1:0] bearing_by_py;
    logic signed [DATA_W-1:0] rate_by_px;
    logic signed [DATA_W-1:0] rate_by_py;
    logic                     too_close;
  } out_word_t;

  // Per-item values carried alongside the square root
  typedef struct packed {
    logic              pneg;
    logic              qneg;
    logic              cneg;
    logic              too_close;
    logic [DATA_W-1:0] ap;
    logic [DATA_W-1:0] aq;
    logic [SQ_W-1:0]   cmag;
    logic [SQ_W-1:0]   s;
  } side_t;

endpackage

>>> sv/rmj_front.sv
// Front stages: magnitudes, squared distance, cross term and near-range check.
`timescale 1ns / 1ps
module rmj_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  rmj_pkg::in_word_t       in_data,
  input  logic [rmj_pkg::DATA_W-1:0] min_range_squared,
  output logic                    valid,
  output rmj_pkg::side_t          side
);
  import rmj_pkg::*;

  logic [DATA_W-1:0]        ap_c, aq_c;
  logic [SQ_W-1:0]          sqp_c, sqq_c;
  logic signed [SQ_W-1:0]   a_c, b_c;

  logic                     v1, pneg1, qneg1;
  logic [DATA_W-1:0]        ap1, aq1;
  logic [SQ_W-1:0]          sqp1, sqq1;
  logic signed [SQ_W-1:0]   a1, b1;

  logic [SQ_W-1:0]          s_c;
  logic signed [SQ_W:0]     d_c, dn_c;
  side_t                    side_c;

  // Take magnitudes and form the products
  assign ap_c  = in_data.pos_x[DATA_W-1] ? (~in_data.pos_x + 32'd1) : in_data.pos_x;
  assign aq_c  = in_data.pos_y[DATA_W-1] ? (~in_data.pos_y + 32'd1) : in_data.pos_y;
  assign sqp_c = SQ_W'(ap_c) * SQ_W'(ap_c);
  assign sqq_c = SQ_W'(aq_c) * SQ_W'(aq_c);
  assign a_c   = SQ_W'(in_data.vel_x) * SQ_W'(in_data.pos_y);
  assign b_c   = SQ_W'(in_data.vel_y) * SQ_W'(in_data.pos_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      pneg1 <= in_data.pos_x[DATA_W-1];
      qneg1 <= in_data.pos_y[DATA_W-1];
      ap1   <= ap_c;
      aq1   <= aq_c;
      sqp1  <= sqp_c;
      sqq1  <= sqq_c;
      a1    <= a_c;
      b1    <= b_c;
    end
  end

  // Sum the squares, take the cross term apart into sign and magnitude
  assign s_c  = sqp1 + sqq1;
  assign d_c  = (SQ_W+1)'(a1) - (SQ_W+1)'(b1);
  assign dn_c = -d_c;

  always_comb begin
    side_c.pneg      = pneg1;
    side_c.qneg      = qneg1;
    side_c.cneg      = d_c[SQ_W];
    side_c.cmag      = d_c[SQ_W] ? dn_c[SQ_W-1:0] : d_c[SQ_W-1:0];
    side_c.ap        = ap1;
    side_c.aq        = aq1;
    side_c.s         = s_c;
    side_c.too_close = (s_c == '0) ||
                       (s_c < {{(SQ_W-DATA_W-FRAC_W){1'b0}}, min_range_squared,
                               {FRAC_W{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= v1;
    end
    if (en) begin
      side <= side_c;
    end
  end

endmodule

>>> sv/rmj_isqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module rmj_isqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [rmj_pkg::SQ_W-1:0]    value,
  output logic [rmj_pkg::ROOT_W-1:0]  root
);
  import rmj_pkg::*;

  localparam int TW = SQ_W + 2;

  logic [SQ_W-1:0]   rem_q  [0:ROOT_W-1];
  logic [ROOT_W-1:0] root_q [0:ROOT_W-1];

  genvar k;
  generate
    for (k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int BI = ROOT_W - 1 - k;
      logic [SQ_W-1:0]   rem_in;
      logic [ROOT_W-1:0] root_in;
      logic [TW-1:0]     trial;
      logic              take;

      if (k == 0) begin : g_first
        assign rem_in  = value;
        assign root_in = '0;
      end else begin : g_next
        assign rem_in  = rem_q[k-1];
        assign root_in = root_q[k-1];
      end

      // Try setting this root bit: (root + 2^i)^2 - root^2
      assign trial = (TW'(root_in) << (BI + 1)) + (TW'(1) << (2 * BI));
      assign take  = TW'(rem_in) >= trial;

      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k]  <= take ? SQ_W'(TW'(rem_in) - trial) : rem_in;
          root_q[k] <= take ? (root_in | (ROOT_W'(1) << BI)) : root_in;
        end
      end
    end
  endgenerate

  assign root = root_q[ROOT_W-1];

endmodule

>>> sv/rmj_div.sv
// Pipelined restoring divider with rounding and Q16.16 saturation.
`timescale 1ns / 1ps
module rmj_div #(
  parameter int NUM_W = rmj_pkg::DEF_NUM_W,
  parameter int DEN_W = rmj_pkg::DEF_DEN_W
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [NUM_W-1:0]            num,
  input  logic [DEN_W-1:0]            den,
  input  logic                        neg,
  output logic [rmj_pkg::DATA_W-1:0]  quo
);
  import rmj_pkg::*;

  localparam int W = (NUM_W + 1 > DEN_W + QBITS) ? NUM_W + 1 : DEN_W + QBITS;

  logic [W-1:0]     rem_q [0:QBITS];
  logic [QBITS-1:0] q_q   [0:QBITS];
  logic [DEN_W-1:0] den_q [0:QBITS];
  logic             neg_q [0:QBITS];
  logic             ovf_q [0:QBITS];

  logic [QBITS:0]    rnd;
  logic [QBITS-1:0]  rq;
  logic [DATA_W-1:0] quo_next;

  // Load twice the numerator, flag quotients of 2^32 and above
  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= W'(num) << 1;
      q_q[0]   <= '0;
      den_q[0] <= den;
      neg_q[0] <= neg;
      ovf_q[0] <= W'(num) >= (W'(den) << (QBITS - 1));
    end
  end

  genvar k;
  generate
    for (k = 1; k <= QBITS; k++) begin : g_stage
      localparam int BI = QBITS - k;
      logic [W-1:0] trial;
      logic         take;

      assign trial = W'(den_q[k-1]) << BI;
      assign take  = rem_q[k-1] >= trial;

      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= take ? (rem_q[k-1] - trial) : rem_q[k-1];
          q_q[k]   <= take ? (q_q[k-1] | (QBITS'(1) << BI)) : q_q[k-1];
          den_q[k] <= den_q[k-1];
          neg_q[k] <= neg_q[k-1];
          ovf_q[k] <= ovf_q[k-1];
        end
      end
    end
  endgenerate

  // Round half away from zero, apply sign and saturate
  assign rnd = {1'b0, q_q[QBITS]} + (QBITS+1)'(1);
  assign rq  = rnd[QBITS:1];

  always_comb begin
    if (neg_q[QBITS]) begin
      if (ovf_q[QBITS] || rq > {1'b0, SAT_NEG}) begin
        quo_next = SAT_NEG;
      end else begin
        quo_next = ~rq[DATA_W-1:0] + DATA_W'(1);
      end
    end else begin
      if (ovf_q[QBITS] || rq > {1'b0, SAT_POS}) begin
        quo_next = SAT_POS;
      end else begin
        quo_next = rq[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= quo_next;
    end
  end

endmodule

>>> sv/radar_measurement_jacobian_unit.sv
// Top level of the radar measurement Jacobian pipeline.
//
// Input channel in_valid/in_stall/in_data carries one tracking state word
// (pos_x, pos_y, vel_x, vel_y, signed Q16.16). Output channel
// out_valid/out_stall/out_data carries the six Jacobian entries in signed
// Q16.16, saturated, plus too_close; when too_close is set all entries are 0.
// The cfg_valid/cfg_ready/cfg_data port writes min_range_squared; cfg_ready
// is always high. Write it only while no word is in flight.
//
// From input acceptance to out_valid a word passes through 2 front stages,
// 32 square-root stages (one root bit each), 2 product stages and 35 divider
// stages (33 quotient bits, a load stage and a rounding stage).
// Throughput is one word per cycle while out_stall does not hold the pipeline.
//
// Reset clears all valid bits and sets min_range_squared to 7.
// While out_valid is high and out_stall is high the whole pipeline holds and
// in_stall is raised; no word is lost or repeated.
`timescale 1ns / 1ps
module radar_measurement_jacobian_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rmj_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output rmj_pkg::out_word_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rmj_pkg::DATA_W-1:0]     cfg_data
);
  import rmj_pkg::*;

  localparam int NUM1_W = DATA_W + FRAC_W;
  localparam int NUM2_W = 2 * DATA_W;
  localparam int NUM3_W = PROD_W + FRAC_W;

  logic              en;
  logic [DATA_W-1:0] min_range_squared;

  logic              f_valid;
  side_t             f_side;
  logic [ROOT_W-1:0] root;

  logic              sd_valid [0:SQRT_LAT-1];
  side_t             sd_side  [0:SQRT_LAT-1];

  logic              v1;
  side_t             side1;
  logic [ROOT_W-1:0] r1;
  logic [SQ_W-1:0]   sr_lo1, sr_hi1, pq_lo1, pq_hi1, pp_lo1, pp_hi1;

  logic              v2, tc2, pneg2, qneg2, cneg2;
  logic [ROOT_W-1:0] den_r2;
  logic [SQ_W-1:0]   den_s2;
  logic [PROD_W-1:0] den3_2;
  logic [NUM1_W-1:0] nap16_2, naq16_2;
  logic [NUM2_W-1:0] nap32_2, naq32_2;
  logic [NUM3_W-1:0] nq3_2, np3_2;

  logic              od_valid [0:DIV_LAT-1];
  logic              od_tc    [0:DIV_LAT-1];

  logic [DATA_W-1:0] e0, e1, e2, e3, e4, e5;
  logic              tc_out;

  // Advance the whole pipeline unless the output word is held
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // Hold the range threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_range_squared <= MIN_RANGE_SQ_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_range_squared <= cfg_data;
    end
  end

  rmj_front u_front (
    .clk               (clk),
    .rst               (rst),
    .en                (en),
    .in_valid          (in_valid),
    .in_data           (in_data),
    .min_range_squared (min_range_squared),
    .valid             (f_valid),
    .side              (f_side)
  );

  rmj_isqrt u_isqrt (
    .clk   (clk),
    .en    (en),
    .value (f_side.s),
    .root  (root)
  );

  // Carry valid and operands alongside the square root
  always_ff @(posedge clk) begin
    for (int i = 0; i < SQRT_LAT; i++) begin
      if (rst) begin
        sd_valid[i] <= 1'b0;
      end else if (en) begin
        sd_valid[i] <= (i == 0) ? f_valid : sd_valid[(i == 0) ? 0 : i - 1];
      end
      if (en) begin
        sd_side[i] <= (i == 0) ? f_side : sd_side[(i == 0) ? 0 : i - 1];
      end
    end
  end

  // Form 32x32 partial products of the wide terms
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= sd_valid[SQRT_LAT-1];
    end
    if (en) begin
      side1  <= sd_side[SQRT_LAT-1];
      r1     <= root;
      sr_lo1 <= SQ_W'(sd_side[SQRT_LAT-1].s[DATA_W-1:0]) * SQ_W'(root);
      sr_hi1 <= SQ_W'(sd_side[SQRT_LAT-1].s[SQ_W-1:DATA_W]) * SQ_W'(root);
      pq_lo1 <= SQ_W'(sd_side[SQRT_LAT-1].aq) * SQ_W'(sd_side[SQRT_LAT-1].cmag[DATA_W-1:0]);
      pq_hi1 <= SQ_W'(sd_side[SQRT_LAT-1].aq) *
                SQ_W'(sd_side[SQRT_LAT-1].cmag[SQ_W-1:DATA_W]);
      pp_lo1 <= SQ_W'(sd_side[SQRT_LAT-1].ap) * SQ_W'(sd_side[SQRT_LAT-1].cmag[DATA_W-1:0]);
      pp_hi1 <= SQ_W'(sd_side[SQRT_LAT-1].ap) *
                SQ_W'(sd_side[SQRT_LAT-1].cmag[SQ_W-1:DATA_W]);
    end
  end

  // Sum partial products and line up the numerators
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      tc2     <= side1.too_close;
      pneg2   <= side1.pneg;
      qneg2   <= side1.qneg;
      cneg2   <= side1.cneg;
      den_r2  <= r1;
      den_s2  <= side1.s;
      den3_2  <= PROD_W'(sr_lo1) + (PROD_W'(sr_hi1) << DATA_W);
      nap16_2 <= NUM1_W'(side1.ap) << FRAC_W;
      naq16_2 <= NUM1_W'(side1.aq) << FRAC_W;
      nap32_2 <= NUM2_W'(side1.ap) << DATA_W;
      naq32_2 <= NUM2_W'(side1.aq) << DATA_W;
      nq3_2   <= NUM3_W'(PROD_W'(pq_lo1) + (PROD_W'(pq_hi1) << DATA_W)) << FRAC_W;
      np3_2   <= NUM3_W'(PROD_W'(pp_lo1) + (PROD_W'(pp_hi1) << DATA_W)) << FRAC_W;
    end
  end

  rmj_div #(.NUM_W(NUM1_W), .DEN_W(ROOT_W)) u_div_rpx (
    .clk (clk), .en (en), .num (nap16_2), .den (den_r2), .neg (pneg2), .quo (e0)
  );

  rmj_div #(.NUM_W(NUM1_W), .DEN_W(ROOT_W)) u_div_rpy (
    .clk (clk), .en (en), .num (naq16_2), .den (den_r2), .neg (qneg2), .quo (e1)
  );

  rmj_div #(.NUM_W(NUM2_W), .DEN_W(SQ_W)) u_div_bpx (
    .clk (clk), .en (en), .num (naq32_2), .den (den_s2), .neg (!qneg2), .quo (e2)
  );

  rmj_div #(.NUM_W(NUM2_W), .DEN_W(SQ_W)) u_div_bpy (
    .clk (clk), .en (en), .num (nap32_2), .den (den_s2), .neg (pneg2), .quo (e3)
  );

  rmj_div #(.NUM_W(NUM3_W), .DEN_W(PROD_W)) u_div_cpx (
    .clk (clk), .en (en), .num (nq3_2), .den (den3_2), .neg (qneg2 ^ cneg2), .quo (e4)
  );

  rmj_div #(.NUM_W(NUM3_W), .DEN_W(PROD_W)) u_div_cpy (
    .clk (clk), .en (en), .num (np3_2), .den (den3_2), .neg (!(pneg2 ^ cneg2)), .quo (e5)
  );

  // Carry valid and the near-range flag alongside the dividers
  always_ff @(posedge clk) begin
    for (int i = 0; i < DIV_LAT; i++) begin
      if (rst) begin
        od_valid[i] <= 1'b0;
      end else if (en) begin
        od_valid[i] <= (i == 0) ? v2 : od_valid[(i == 0) ? 0 : i - 1];
      end
      if (en) begin
        od_tc[i] <= (i == 0) ? tc2 : od_tc[(i == 0) ? 0 : i - 1];
      end
    end
  end

  // Drive the output word, zeroed when too close
  assign out_valid = od_valid[DIV_LAT-1];
  assign tc_out    = od_tc[DIV_LAT-1];

  always_comb begin
    out_data.range_by_px   = tc_out ? '0 : e0;
    out_data.range_by_py   = tc_out ? '0 : e1;
    out_data.bearing_by_px = tc_out ? '0 : e2;
    out_data.bearing_by_py = tc_out ? '0 : e3;
    out_data.rate_by_px    = tc_out ? '0 : e4;
    out_data.rate_by_py    = tc_out ? '0 : e5;
    out_data.too_close     = tc_out;
  end

endmodule

>>> dv/tb_radar_measurement_jacobian_unit.sv
// Self-checking testbench for the radar measurement Jacobian pipeline.
`timescale 1ns / 1ps
module tb_radar_measurement_jacobian_unit;
  import rmj_pkg::*;

  localparam int LATENCY = 71;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [DATA_W-1:0] cfg_data = '0;

  logic [31:0] min_range_sq = MIN_RANGE_SQ_RESET;
  out_word_t jacobian_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  radar_measurement_jacobian_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Divide num by den, round half away from zero, apply sign, saturate
  function automatic logic [31:0] round_sat(logic [127:0] num, logic [127:0] den, bit neg);
    logic [127:0] q;
    logic [127:0] rem;
    q = num / den;
    rem = num % den;
    if ((rem << 1) >= den) q = q + 1;
    if (neg) begin
      if (q > 128'h8000_0000) return SAT_NEG;
      return 32'(-q[31:0]);
    end
    if (q > 128'h7FFF_FFFF) return SAT_POS;
    return q[31:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      logic [63:0] t;
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic out_word_t jacobian_of(in_word_t w);
    out_word_t o;
    logic signed [63:0] p, q, vx, vy, a, b;
    logic [63:0] ap, aq, s, r, cmag;
    logic [127:0] den3;
    bit cneg;
    p = w.pos_x; q = w.pos_y; vx = w.vel_x; vy = w.vel_y;
    o = '0;
    ap = p < 0 ? -p : p;
    aq = q < 0 ? -q : q;
    s = ap * ap + aq * aq;
    if (s == 0 || s < ({32'd0, min_range_sq} << 16)) begin
      o.too_close = 1'b1;
      return o;
    end
    r = int_sqrt(s);
    a = vx * q;
    b = vy * p;
    cneg = a < b;
    cmag = cneg ? b - a : a - b;
    den3 = 128'(s) * 128'(r);
    o.range_by_px = round_sat(128'(ap) << 16, 128'(r), p < 0);
    o.range_by_py = round_sat(128'(aq) << 16, 128'(r), q < 0);
    o.bearing_by_px = round_sat(128'(aq) << 32, 128'(s), q > 0);
    o.bearing_by_py = round_sat(128'(ap) << 32, 128'(s), p < 0);
    o.rate_by_px = round_sat((128'(aq) * 128'(cmag)) << 16, den3, (q < 0) != cneg);
    o.rate_by_py = round_sat((128'(ap) * 128'(cmag)) << 16, den3, !((p < 0) != cneg));
    if (cmag == 0 || q == 0) o.rate_by_px = '0;
    if (cmag == 0 || p == 0) o.rate_by_py = '0;
    return o;
  endfunction

  // Send one word; valid stays high until the next word or a drain drops it
  task automatic send_state(in_word_t w);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    jacobian_q.push_back(jacobian_of(w));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (jacobian_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic write_threshold(logic [31:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    min_range_sq = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
      2: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
      default: return 32'($signed($urandom_range(0, 255)) - 128);
    endcase
  endfunction

  task automatic test_extremes();
    logic [31:0] ext[6] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF,
                            32'h0001_0000};
    for (int i = 0; i < 6; i++)
      send_state('{ext[i], ext[(i + 2) % 6], ext[(i + 1) % 6], ext[(i + 4) % 6]});
    // zero distance, near threshold, exact cancel of the cross term
    send_state('{32'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000});
    send_state('{32'd0, 32'd677, 32'd5, 32'd5});
    send_state('{32'd677, 32'd0, 32'd5, 32'd5});
    send_state('{32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0002_0000});
    send_state('{32'hFFFF_0000, 32'h0003_0000, 32'h0, 32'h0});
  endtask

  task automatic test_thresholds();
    write_threshold(32'd0);
    send_state('{32'd0, 32'd0, 32'd1, 32'd1});
    send_state('{32'd1, 32'd0, 32'd1, 32'd1});
    write_threshold(32'hFFFF_FFFF);
    send_state('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'd1});
    send_state('{32'h8000_0000, 32'h8000_0000, 32'd1, 32'd1});
    send_state('{32'h0100_0000, 32'h0, 32'd1, 32'd1});
    write_threshold(32'h0001_0000);
    send_state('{32'h0001_0000, 32'h0, 32'd1, 32'd1});
    send_state('{32'h0000_FFFF, 32'h0, 32'd1, 32'd1});
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) write_threshold($urandom_range(0, 64));
      if (i == 2 * n / 3) write_threshold($urandom());
      if (i == 5 * n / 6) begin
        write_threshold(MIN_RANGE_SQ_RESET);
        quiet = 1'b1;
      end
      send_state('{rand_coord(), rand_coord(), rand_coord(), rand_coord()});
    end
  endtask

  // Stall the output in random bursts
  always @(negedge clk) begin
    if (rst || quiet) begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!out_stall && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (jacobian_q.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        out_word_t e;
        e = jacobian_q.pop_front();
        if (out_data.range_by_px !== e.range_by_px) begin
          $error("range_by_px exp %h got %h", e.range_by_px, out_data.range_by_px); errors++;
        end
        if (out_data.range_by_py !== e.range_by_py) begin
          $error("range_by_py exp %h got %h", e.range_by_py, out_data.range_by_py); errors++;
        end
        if (out_data.bearing_by_px !== e.bearing_by_px) begin
          $error("bearing_by_px exp %h got %h", e.bearing_by_px, out_data.bearing_by_px);
          errors++;
        end
        if (out_data.bearing_by_py !== e.bearing_by_py) begin
          $error("bearing_by_py exp %h got %h", e.bearing_by_py, out_data.bearing_by_py);
          errors++;
        end
        if (out_data.rate_by_px !== e.rate_by_px) begin
          $error("rate_by_px exp %h got %h", e.rate_by_px, out_data.rate_by_px); errors++;
        end
        if (out_data.rate_by_py !== e.rate_by_py) begin
          $error("rate_by_py exp %h got %h", e.rate_by_py, out_data.rate_by_py); errors++;
        end
        if (out_data.too_close !== e.too_close) begin
          $error("too_close exp %b got %b", e.too_close, out_data.too_close); errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    // hold off until the pipeline is empty
    drain();
    test_thresholds();
    write_threshold(MIN_RANGE_SQ_RESET);
    test_random(650);
    drain();
    if (errors == 0 && jacobian_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

>>> filelist.f
sv/rmj_pkg.sv
sv/rmj_front.sv
sv/rmj_isqrt.sv
sv/rmj_div.sv
sv/radar_measurement_jacobian_unit.sv
dv/tb_radar_measurement_jacobian_unit.sv
